// File: rtl/fupd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fupd_pkg;

  // Parser phase, one-hot
  typedef enum logic [6:0] {
    PH_SCHEME  = 7'b000_0001,
    PH_HOST    = 7'b000_0010,
    PH_PATH    = 7'b000_0100,
    PH_HIGH    = 7'b000_1000,
    PH_LOW     = 7'b001_0000,
    PH_STOPPED = 7'b010_0000,
    PH_ERROR   = 7'b100_0000
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_SCHEME = 2'd1,
    ST_BAD_HOST   = 2'd2,
    ST_BAD_ESCAPE = 2'd3
  } status_e;

  localparam logic [2:0] PrefixLast = 3'd6;  // last index of "file://"
  localparam logic [3:0] LocalLen   = 4'd9;  // length of "localhost"

  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChQuery   = 8'h3F;
  localparam logic [7:0] ChHash    = 8'h23;

  typedef struct packed {
    phase_e     phase;
    logic [2:0] scheme_pos;
    logic [3:0] host_pos;
    logic       host_mismatch;
    logic [3:0] high_nibble;
    status_e    first_err;
  } state_t;

  localparam state_t StateReset = '{
    phase:         PH_SCHEME,
    scheme_pos:    3'd0,
    host_pos:      4'd0,
    host_mismatch: 1'b0,
    high_nibble:   4'd0,
    first_err:     ST_OK
  };

  typedef struct packed {
    logic       emit;
    logic       has_byte;
    logic [7:0] path_byte;
    logic       end_of_uri;
    status_e    status;
  } result_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h66;  // f
      3'd1:    ch = 8'h69;  // i
      3'd2:    ch = 8'h6C;  // l
      3'd3:    ch = 8'h65;  // e
      3'd4:    ch = 8'h3A;  // :
      default: ch = ChSlash;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] local_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h6C;  // l
      4'd1:    ch = 8'h6F;  // o
      4'd2:    ch = 8'h63;  // c
      4'd3:    ch = 8'h61;  // a
      4'd4:    ch = 8'h6C;  // l
      4'd5:    ch = 8'h68;  // h
      4'd6:    ch = 8'h6F;  // o
      4'd7:    ch = 8'h73;  // s
      4'd8:    ch = 8'h74;  // t
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    d = 8'h00;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      r = {1'b1, d[3:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/fupd_step.sv
`timescale 1ns / 1ps
`default_nettype none

module fupd_step (
  input  fupd_pkg::state_t  state_i,
  input  logic [7:0]        uri_byte_i,
  input  logic              is_final_i,
  output fupd_pkg::state_t  state_o,
  output fupd_pkg::result_t result_o
);
  import fupd_pkg::*;

  state_t     nxt;
  logic       has;
  logic [7:0] pb;
  logic [4:0] hex;
  status_e    st;

  always_comb begin
    nxt = state_i;
    has = 1'b0;
    pb  = 8'h00;
    hex = hex_value(uri_byte_i);

    case (state_i.phase)
      PH_SCHEME: begin
        if (to_lower(uri_byte_i) == prefix_char(state_i.scheme_pos)) begin
          if (state_i.scheme_pos >= PrefixLast) begin
            nxt.phase      = PH_HOST;
            nxt.scheme_pos = 3'd0;
          end else begin
            nxt.scheme_pos = state_i.scheme_pos + 3'd1;
          end
        end else begin
          nxt.phase     = PH_ERROR;
          nxt.first_err = ST_BAD_SCHEME;
        end
      end
      PH_HOST: begin
        if (uri_byte_i == ChSlash) begin
          if (state_i.host_pos == 4'd0 ||
              (state_i.host_pos == LocalLen && !state_i.host_mismatch)) begin
            nxt.phase = PH_PATH;
            has       = 1'b1;
            pb        = uri_byte_i;
          end else begin
            nxt.phase     = PH_ERROR;
            nxt.first_err = ST_BAD_HOST;
          end
        end else if (state_i.host_pos < LocalLen) begin
          if (uri_byte_i != local_char(state_i.host_pos)) begin
            nxt.host_mismatch = 1'b1;
          end
          nxt.host_pos = state_i.host_pos + 4'd1;
        end else begin
          nxt.host_mismatch = 1'b1;
        end
      end
      PH_PATH: begin
        if (uri_byte_i == ChQuery || uri_byte_i == ChHash) begin
          nxt.phase = PH_STOPPED;
        end else if (uri_byte_i == ChPercent) begin
          nxt.phase = PH_HIGH;
        end else begin
          has = 1'b1;
          pb  = uri_byte_i;
        end
      end
      PH_HIGH: begin
        if (!hex[4]) begin
          nxt.phase     = PH_ERROR;
          nxt.first_err = ST_BAD_ESCAPE;
        end else begin
          nxt.high_nibble = hex[3:0];
          nxt.phase       = PH_LOW;
        end
      end
      PH_LOW: begin
        if (!hex[4] || (state_i.high_nibble == 4'd0 && hex[3:0] == 4'd0)) begin
          nxt.phase     = PH_ERROR;
          nxt.first_err = ST_BAD_ESCAPE;
        end else begin
          has       = 1'b1;
          pb        = {state_i.high_nibble, hex[3:0]};
          nxt.phase = PH_PATH;
        end
      end
      default: begin
        // stopped and error: input ignored
      end
    endcase

    // end status taken from the phase after this byte
    case (nxt.phase)
      PH_SCHEME:  st = ST_BAD_SCHEME;
      PH_HOST:    st = ST_BAD_HOST;
      PH_HIGH:    st = ST_BAD_ESCAPE;
      PH_LOW:     st = ST_BAD_ESCAPE;
      PH_PATH:    st = ST_OK;
      PH_STOPPED: st = ST_OK;
      default:    st = nxt.first_err;
    endcase
    if (!is_final_i) begin
      st = ST_OK;
    end

    result_o.emit       = has | is_final_i;
    result_o.has_byte   = has;
    result_o.path_byte  = pb;
    result_o.end_of_uri = is_final_i;
    result_o.status     = st;

    state_o = is_final_i ? StateReset : nxt;
  end

endmodule

`default_nettype wire

// File: rtl/file_uri_path_decoder.sv
// A result is registered in the output register, or in the skid stage while the output is held.
// Throughput: one byte per cycle while the skid stage is empty; the parse step is a single combinational pass
//   between the parser state register and the output register.
// A skid stage behind the output register absorbs one result of output stall;
//   input ready drops only while that stage is occupied.
// Reset (rst_ni low, asynchronous): scheme matching, stages empty; also after each final byte.
`timescale 1ns / 1ps
`default_nettype none

module file_uri_path_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] uri_byte_i,
  input  logic       is_final_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       has_byte_o,
  output logic [7:0] path_byte_o,
  output logic       end_of_uri_o,
  output logic [1:0] status_o
);
  import fupd_pkg::*;

  // parser state
  state_t  state_q, state_d;
  result_t step_res;

  // output register and skid stage
  logic    out_vld_q, out_vld_d;
  logic    skid_vld_q, skid_vld_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;

  logic in_xfer;
  logic out_xfer;
  logic push;

  fupd_step u_step (
    .state_i    (state_q),
    .uri_byte_i (uri_byte_i),
    .is_final_i (is_final_i),
    .state_o    (state_d),
    .result_o   (step_res)
  );

  assign in_ready_o = !skid_vld_q;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_xfer   = out_vld_q && out_ready_i;
  assign push       = in_xfer && step_res.emit;  // byte or end marker

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      // no input transfer possible here; drain skid into output
      if (out_xfer) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (push) begin
      if (!out_vld_q || out_xfer) begin
        out_d     = step_res;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = step_res;
        skid_vld_d = 1'b1;
      end
    end else if (out_xfer) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StateReset;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_q <= state_d;
      end
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o  = out_vld_q;
  assign has_byte_o   = out_q.has_byte;
  assign path_byte_o  = out_q.path_byte;
  assign end_of_uri_o = out_q.end_of_uri;
  assign status_o     = out_q.status;

`ifndef SYNTHESIS
  // skid stage only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid stage occupied with output register empty");

  // every result carries a byte or marks the end
  a_result_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.has_byte || out_q.end_of_uri))
    else $error("empty result presented");

  // status only reported on the end result
  a_status_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.end_of_uri) |-> (out_q.status == ST_OK))
    else $error("status set on a non-final result");

  // parser restarts after the final byte
  a_restart_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && is_final_i) |=> (state_q.phase == PH_SCHEME))
    else $error("parser did not restart after final byte");
`endif

endmodule

`default_nettype wire

// File: tb/uri_path_checker.sv
`timescale 1ns / 1ps

module uri_path_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  uri_byte_i,
  input  logic        is_final_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        has_byte_i,
  input  logic [7:0]  path_byte_i,
  input  logic        end_of_uri_i,
  input  logic [1:0]  status_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);
  import fupd_pkg::*;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] path_byte;
    logic       end_of_uri;
    status_e    status;
  } path_result_t;

  localparam logic [8*7-1:0] SchemeText = "file://";
  localparam logic [8*9-1:0] HostText   = "localhost";

  // decoder state, mirrored
  phase_e     uri_phase;
  logic [2:0] scheme_pos;
  logic [3:0] host_pos;
  logic       host_bad;
  logic [3:0] escape_high;
  status_e    first_error;

  path_result_t expected_path_results[$];
  path_result_t predicted;
  path_result_t observed;

  function automatic void restart_decoder();
    uri_phase   = PH_SCHEME;
    scheme_pos  = 3'd0;
    host_pos    = 4'd0;
    host_bad    = 1'b0;
    escape_high = 4'd0;
    first_error = ST_OK;
  endfunction

  function automatic void enter_error(input status_e code);
    uri_phase   = PH_ERROR;
    first_error = code;
  endfunction

  // nibble value, or -1 when not a hex digit
  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  // one URI byte through the decoder; returns 1 when it yields a result
  function automatic bit decode_uri_byte(input logic [7:0] b, input logic fin,
                                         output path_result_t res);
    logic       has;
    logic [7:0] pb;
    logic [7:0] lower;
    int         d;
    status_e    st;
    has   = 1'b0;
    pb    = 8'h00;
    st    = ST_OK;
    res   = '0;
    case (uri_phase)
      PH_SCHEME: begin
        lower = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        if (lower == SchemeText[8*(6-int'(scheme_pos)) +: 8]) begin
          if (scheme_pos >= PrefixLast) begin
            uri_phase  = PH_HOST;
            scheme_pos = 3'd0;
          end else begin
            scheme_pos = scheme_pos + 3'd1;
          end
        end else begin
          enter_error(ST_BAD_SCHEME);
        end
      end
      PH_HOST: begin
        if (b == ChSlash) begin
          if (host_pos == 4'd0 || (host_pos == LocalLen && !host_bad)) begin
            uri_phase = PH_PATH;
            has       = 1'b1;
            pb        = b;
          end else begin
            enter_error(ST_BAD_HOST);
          end
        end else if (host_pos < LocalLen) begin
          if (b != HostText[8*(8-int'(host_pos)) +: 8]) host_bad = 1'b1;
          host_pos = host_pos + 4'd1;
        end else begin
          host_bad = 1'b1;
        end
      end
      PH_PATH: begin
        if (b == ChQuery || b == ChHash) begin
          uri_phase = PH_STOPPED;
        end else if (b == ChPercent) begin
          uri_phase = PH_HIGH;
        end else begin
          has = 1'b1;
          pb  = b;
        end
      end
      PH_HIGH: begin
        d = nibble_of(b);
        if (d < 0) begin
          enter_error(ST_BAD_ESCAPE);
        end else begin
          escape_high = d[3:0];
          uri_phase   = PH_LOW;
        end
      end
      PH_LOW: begin
        d = nibble_of(b);
        if (d < 0 || (escape_high == 4'd0 && d == 0)) begin
          enter_error(ST_BAD_ESCAPE);
        end else begin
          has       = 1'b1;
          pb        = {escape_high, d[3:0]};
          uri_phase = PH_PATH;
        end
      end
      default: ;
    endcase
    if (!has && !fin) return 1'b0;
    if (fin) begin
      case (uri_phase)
        PH_SCHEME:          st = ST_BAD_SCHEME;
        PH_HOST:            st = ST_BAD_HOST;
        PH_HIGH, PH_LOW:    st = ST_BAD_ESCAPE;
        PH_PATH, PH_STOPPED: st = ST_OK;
        default:            st = first_error;
      endcase
    end
    res.has_byte   = has;
    res.path_byte  = pb;
    res.end_of_uri = fin;
    res.status     = st;
    if (fin) restart_decoder();
    return 1'b1;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count_o = fail_count_o + 1;
    if (fail_count_o <= 10) $display("%0t: %s", $time, msg);
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    restart_decoder();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_decoder();
      expected_path_results.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (decode_uri_byte(uri_byte_i, is_final_i, predicted))
          expected_path_results = {expected_path_results, predicted};
      end
      if (out_valid_i && out_ready_i) begin
        observed.has_byte   = has_byte_i;
        observed.path_byte  = path_byte_i;
        observed.end_of_uri = end_of_uri_i;
        observed.status     = status_e'(status_i);
        if (expected_path_results.size() == 0) begin
          note_failure($sformatf("unexpected result: has=%0b byte=%02h end=%0b status=%0d",
                                 has_byte_i, path_byte_i, end_of_uri_i, status_i));
        end else begin
          predicted = expected_path_results.pop_front();
          if (observed.has_byte !== predicted.has_byte ||
              observed.path_byte !== predicted.path_byte ||
              observed.end_of_uri !== predicted.end_of_uri ||
              observed.status !== predicted.status)
            note_failure($sformatf({"result mismatch: expected has=%0b byte=%02h end=%0b ",
                                    "status=%0d, got has=%0b byte=%02h end=%0b status=%0d"},
                                   predicted.has_byte, predicted.path_byte,
                                   predicted.end_of_uri, predicted.status,
                                   has_byte_i, path_byte_i, end_of_uri_i, status_i));
        end
      end
    end
    pending_o = expected_path_results.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fupd_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] uri_byte_i;
  logic       is_final_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       has_byte_o;
  logic [7:0] path_byte_o;
  logic       end_of_uri_o;
  logic [1:0] status_o;

  int unsigned pending;
  int unsigned fail_count;

  // Stimulus control shared between the sender and the receiver processes.
  int unsigned sent_count;
  bit          sender_gaps;     // random gaps on the input side for this URI
  bit          settle_phase;    // last stretch of the run: no idling anywhere
  bit          hold_request;    // ask the receiver for one long hold-off
  bit          hold_issued;

  logic [7:0] uri_text[$];      // URI under construction, sent as a whole

  file_uri_path_decoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .uri_byte_i   (uri_byte_i),
    .is_final_i   (is_final_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .has_byte_o   (has_byte_o),
    .path_byte_o  (path_byte_o),
    .end_of_uri_o (end_of_uri_o),
    .status_o     (status_o)
  );

  uri_path_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .uri_byte_i   (uri_byte_i),
    .is_final_i   (is_final_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .has_byte_i   (has_byte_o),
    .path_byte_i  (path_byte_o),
    .end_of_uri_i (end_of_uri_o),
    .status_i     (status_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard limit, far above the slowest legal run.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: ready changes only at the falling edge, one assignment per edge.
  // Short random stalls, plus a single long hold-off on request
  // so that the output stages fill and the input side has to stall.
  initial begin : receiver
    int unsigned stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = 59;
        out_ready_i <= 1'b0;
      end else if (!settle_phase && $urandom_range(0, 5) == 0) begin
        stall_left   = $urandom_range(0, 3);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // append one byte to the URI under construction
  function automatic void add_char(input logic [7:0] c);
    uri_text = {uri_text, c};
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
    return c;
  endfunction

  function automatic void append_text(input string s, input bit mixed_case);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mixed_case && c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
      add_char(c);
    end
  endfunction

  // One transfer on the input channel. Called at a falling edge, returns at
  // the falling edge after the transfer. Valid stays high between back-to-back
  // bytes, so there is one assignment to it per edge.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (sender_gaps && !settle_phase && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    uri_byte_i <= b;
    is_final_i <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic send_uri();
    for (int i = 0; i < uri_text.size(); i++)
      send_byte(uri_text[i], i == uri_text.size() - 1);
    uri_text.delete();
  endtask

  // Random URI: mostly well formed with random content, some broken on
  // purpose (bad or short prefix, wrong host, no slash, bad escapes,
  // truncated escapes) so that every error path is walked.
  task automatic compose_uri();
    int unsigned flavour;
    int unsigned host_kind;
    int unsigned n;
    int unsigned v;
    int unsigned p;
    flavour = $urandom_range(0, 15);
    append_text("file://", 1'b1);
    if (flavour == 0) begin
      // prefix mismatch; the rest is still sent and must be ignored
      p = $urandom_range(0, 6);
      uri_text[p] = 8'($urandom_range(0, 255));
    end else if (flavour == 1) begin
      // URI ends within the prefix
      n = $urandom_range(1, 6);
      while (uri_text.size() > n) void'(uri_text.pop_back());
      return;
    end
    host_kind = $urandom_range(0, 9);
    case (host_kind)
      4, 5: append_text("localhost", 1'b0);
      6: begin
        append_text("localhost", 1'b0);
        p = uri_text.size() - 1 - $urandom_range(0, 8);
        uri_text[p] = uri_text[p] ^ 8'(1 << $urandom_range(0, 7));
      end
      7: repeat ($urandom_range(1, 12)) add_char(8'($urandom_range("a", "z")));
      8: begin
        append_text("localhost", 1'b0);
        repeat ($urandom_range(1, 3)) add_char(8'($urandom_range("a", "z")));
      end
      9: repeat ($urandom_range(10, 13)) add_char(8'($urandom_range(0, 255)));
      default: ;  // empty host
    endcase
    // ending within the host: no slash at all
    if (flavour == 2) return;
    add_char(ChSlash);
    n = $urandom_range(0, 12);
    repeat (n) begin
      v = $urandom_range(0, 19);
      case (v)
        10, 11, 12: add_char(8'($urandom_range(0, 255)));
        13, 14, 15: begin
          p = $urandom_range(1, 255);
          add_char(ChPercent);
          add_char(hex_char(p[7:4]));
          add_char(hex_char(p[3:0]));
        end
        16: begin
          // escape that decodes to zero
          add_char(ChPercent);
          add_char(8'h30);
          add_char(8'h30);
        end
        17: begin
          add_char(ChPercent);
          if ($urandom_range(0, 1)) add_char(hex_char(4'($urandom_range(0, 15))));
          add_char(non_hex_char());
        end
        18: add_char($urandom_range(0, 1) ? ChQuery : ChHash);
        19: add_char(8'h00);
        default: add_char(8'($urandom_range(8'h20, 8'h7E)));
      endcase
    end
    // ending inside an escape
    if (flavour == 3) add_char(ChPercent);
    if (flavour == 4) begin
      add_char(ChPercent);
      add_char(hex_char(4'($urandom_range(0, 15))));
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    uri_byte_i   = 8'h00;
    is_final_i   = 1'b0;
    sent_count   = 0;
    sender_gaps  = 1'b1;
    settle_phase = 1'b0;
    hold_request = 1'b0;
    hold_issued  = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: top byte value as a one-byte URI (prefix mismatch), a URI
    // ending in the prefix on a zero byte, then a mixed-case prefix with an
    // empty host, a zero and an all-ones path byte, a decoded escape, a
    // query mark and a stray percent sign that must be ignored after it.
    add_char(8'hFF);
    send_uri();
    add_char("f");
    add_char(8'h00);
    send_uri();
    append_text("FiLe:///", 1'b0);
    add_char(8'h00);
    add_char(8'hFF);
    append_text("%7e?%", 1'b0);
    send_uri();

    // Random part. One long receiver hold-off part-way through, and a final
    // stretch with no idling on either side.
    while (sent_count < 400) begin
      if (sent_count >= 120 && !hold_issued) begin
        hold_issued  = 1'b1;
        hold_request = 1'b1;
      end
      if (sent_count >= 330) settle_phase = 1'b1;
      sender_gaps = $urandom_range(0, 4) != 0;
      compose_uri();
      send_uri();
    end
    in_valid_i <= 1'b0;

    // drain, then wait a little longer for any stray result to show up
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/fupd_pkg.sv
rtl/fupd_step.sv
rtl/file_uri_path_decoder.sv
tb/uri_path_checker.sv
tb/testbench.sv
